/* sv/hidrp_pkg.sv */
// ----------------------------------------------------------------------------
// hidrp_pkg
// Shared types, item codes and helpers for the HID report descriptor parser.
// ----------------------------------------------------------------------------
package hidrp_pkg;

    // Default width of the report bit position counter
    localparam int POS_WIDTH_DEF = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_STOP_ID = 1'b0;          // index held in paddr[2]
    localparam logic [7:0] STOP_ID_RESET = 8'h02;

    // Item prefixes and usages
    localparam logic [7:0] PFX_LONG       = 8'hFE;
    localparam logic [7:0] PFX_REPORT_ID  = 8'h85;
    localparam logic [7:0] PFX_RPT_COUNT  = 8'h95;
    localparam logic [7:0] PFX_RPT_SIZE   = 8'h75;
    localparam logic [7:0] PFX_USAGE      = 8'h09;
    localparam logic [7:0] PFX_USAGE_PAGE = 8'h05;
    localparam logic [7:0] PFX_INPUT      = 8'h81;

    localparam logic [31:0] USAGE_BUTTON  = 32'h0000_0009;
    localparam logic [31:0] USAGE_AXIS_LO = 32'h0000_0030;
    localparam logic [31:0] USAGE_AXIS_HI = 32'h0000_0035;
    localparam logic [31:0] USAGE_HAT     = 32'h0000_0039;

    localparam int NUM_CLASS = 3;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_SHORT,
        PH_LONG_HDR,
        PH_LONG_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        CLS_BUTTON,
        CLS_AXIS,
        CLS_HAT
    } class_t;

    typedef struct packed {
        logic [15:0] button_count;
        logic [15:0] button_bits;
        logic [23:0] button_start;
        logic [15:0] axis_count;
        logic [15:0] axis_bits;
        logic [23:0] axis_start;
        logic [15:0] hat_count;
        logic [15:0] hat_bits;
        logic [23:0] hat_start;
        logic [23:0] total_bits;
        logic        stopped_early;
        logic        pos_overflow;
    } result_t;

    // Value byte count of a short item: size code 3 means four bytes
    function automatic logic [2:0] short_len(input logic [7:0] prefix);
        logic [2:0] n;
        n = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
        return n;
    endfunction

    // Saturate a 32-bit item value to 16 bits
    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        r = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

/* sv/hidrp_cfg.sv */
// ----------------------------------------------------------------------------
// hidrp_cfg
// APB register slice holding the stop Report ID.
// ----------------------------------------------------------------------------
module hidrp_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hidrp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hidrp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hidrp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [7:0]                         stop_report_id
);

    logic [7:0] stop_id_reg;
    logic [7:0] stop_id_next;
    logic       wr_stop;

    assign wr_stop = psel && penable && pwrite && (paddr[2] == hidrp_pkg::REG_STOP_ID);

    always_comb begin
        stop_id_next = wr_stop ? pwdata[7:0] : stop_id_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_id_reg <= hidrp_pkg::STOP_ID_RESET;
        end else begin
            stop_id_reg <= stop_id_next;
        end
    end

    always_comb begin
        if (paddr[2] == hidrp_pkg::REG_STOP_ID) begin
            prdata = {{(hidrp_pkg::CFG_DATA_W-8){1'b0}}, stop_id_reg};
        end else begin
            prdata = '0;
        end
    end

    assign pready         = 1'b1;
    assign stop_report_id = stop_id_reg;

endmodule

/* sv/hidrp_core.sv */
// ----------------------------------------------------------------------------
// hidrp_core
// Per-byte item walker: parse state, globals, class records, bit position.
// ----------------------------------------------------------------------------
module hidrp_core #(
    parameter int POS_WIDTH = hidrp_pkg::POS_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          desc_byte,
    input  logic                is_last,
    input  logic [7:0]          stop_report_id,
    output logic                result_valid,
    output hidrp_pkg::result_t  result
);

    localparam int NC = hidrp_pkg::NUM_CLASS;

    hidrp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]           prefix_reg, prefix_next;
    logic [8:0]           left_reg, left_next;
    logic [31:0]          accum_reg, accum_next;
    logic [1:0]           idx_reg, idx_next;
    logic [15:0]          count_reg, count_next;
    logic [15:0]          size_reg, size_next;
    logic [31:0]          usage_reg, usage_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                 stop_reg, stop_next;
    logic                 ovf_reg, ovf_next;
    logic [31:0]          prod_reg;
    logic [15:0]          rcnt_reg   [NC];
    logic [15:0]          rcnt_next  [NC];
    logic [15:0]          rsize_reg  [NC];
    logic [15:0]          rsize_next [NC];
    logic [POS_WIDTH-1:0] rstart_reg [NC];
    logic [POS_WIDTH-1:0] rstart_next[NC];

    // Decode of the current byte
    logic        take;
    logic [2:0]  n_len;
    logic [8:0]  left_dec;
    logic [31:0] acc_new;
    logic        finish;
    logic [7:0]  fin_prefix;
    logic [31:0] fin_value;
    logic [32:0] pos_sum;
    logic        pos_sat;
    logic        cls_hit;
    hidrp_pkg::class_t cls;

    assign take     = accept && !stop_reg;
    assign n_len    = hidrp_pkg::short_len(desc_byte);
    assign left_dec = (left_reg != 9'd0) ? left_reg - 9'd1 : 9'd0;
    assign acc_new  = accum_reg | (32'(desc_byte) << {idx_reg, 3'b000});

    always_comb begin
        finish     = 1'b0;
        fin_prefix = prefix_reg;
        fin_value  = acc_new;
        if (take) begin
            unique case (phase_reg)
                hidrp_pkg::PH_PREFIX: begin
                    fin_prefix = desc_byte;
                    fin_value  = 32'd0;
                    finish     = (desc_byte != hidrp_pkg::PFX_LONG) && (n_len == 3'd0);
                end
                hidrp_pkg::PH_SHORT: begin
                    finish = (left_dec == 9'd0);
                end
                default: begin
                    finish = 1'b0;
                end
            endcase
        end
    end

    // Class of the pending usage and the advanced bit position
    always_comb begin
        cls_hit = 1'b1;
        cls     = hidrp_pkg::CLS_BUTTON;
        if (usage_reg == hidrp_pkg::USAGE_BUTTON) begin
            cls = hidrp_pkg::CLS_BUTTON;
        end else if (usage_reg >= hidrp_pkg::USAGE_AXIS_LO &&
                     usage_reg <= hidrp_pkg::USAGE_AXIS_HI) begin
            cls = hidrp_pkg::CLS_AXIS;
        end else if (usage_reg == hidrp_pkg::USAGE_HAT) begin
            cls = hidrp_pkg::CLS_HAT;
        end else begin
            cls_hit = 1'b0;
        end
    end

    assign pos_sum = 33'(pos_reg) + 33'(prod_reg);
    assign pos_sat = |pos_sum[32:POS_WIDTH];

    // Phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                hidrp_pkg::PH_PREFIX: begin
                    if (desc_byte == hidrp_pkg::PFX_LONG) begin
                        phase_next = hidrp_pkg::PH_LONG_HDR;
                    end else if (n_len != 3'd0) begin
                        phase_next = hidrp_pkg::PH_SHORT;
                    end
                end
                hidrp_pkg::PH_SHORT: begin
                    if (left_dec == 9'd0) begin
                        phase_next = hidrp_pkg::PH_PREFIX;
                    end
                end
                hidrp_pkg::PH_LONG_HDR: begin
                    phase_next = hidrp_pkg::PH_LONG_SKIP;
                end
                hidrp_pkg::PH_LONG_SKIP: begin
                    if (left_dec == 9'd0) begin
                        phase_next = hidrp_pkg::PH_PREFIX;
                    end
                end
                default: begin
                    phase_next = hidrp_pkg::PH_PREFIX;
                end
            endcase
        end
        if (accept && is_last) begin
            phase_next = hidrp_pkg::PH_PREFIX;
        end
    end

    // Datapath
    always_comb begin
        prefix_next = prefix_reg;
        left_next   = left_reg;
        accum_next  = accum_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        size_next   = size_reg;
        usage_next  = usage_reg;
        pos_next    = pos_reg;
        stop_next   = stop_reg;
        ovf_next    = ovf_reg;
        rcnt_next   = rcnt_reg;
        rsize_next  = rsize_reg;
        rstart_next = rstart_reg;

        if (take) begin
            unique case (phase_reg)
                hidrp_pkg::PH_PREFIX: begin
                    if (desc_byte != hidrp_pkg::PFX_LONG) begin
                        prefix_next = desc_byte;
                        accum_next  = 32'd0;
                        idx_next    = 2'd0;
                        if (n_len != 3'd0) begin
                            left_next = 9'(n_len);
                        end
                    end
                end
                hidrp_pkg::PH_SHORT: begin
                    accum_next = acc_new;
                    idx_next   = idx_reg + 2'd1;
                    left_next  = left_dec;
                end
                hidrp_pkg::PH_LONG_HDR: begin
                    left_next = 9'(desc_byte) + 9'd1;
                end
                default: begin
                    left_next = left_dec;
                end
            endcase
        end

        if (finish) begin
            if (fin_prefix == hidrp_pkg::PFX_REPORT_ID &&
                fin_value == 32'(stop_report_id)) begin
                stop_next = 1'b1;
            end else begin
                if (fin_prefix == hidrp_pkg::PFX_RPT_COUNT) begin
                    count_next = hidrp_pkg::sat16(fin_value);
                end
                if (fin_prefix == hidrp_pkg::PFX_RPT_SIZE) begin
                    size_next = hidrp_pkg::sat16(fin_value);
                end
                if (fin_prefix == hidrp_pkg::PFX_USAGE ||
                    fin_prefix == hidrp_pkg::PFX_USAGE_PAGE) begin
                    usage_next = fin_value;
                end
                if (fin_prefix == hidrp_pkg::PFX_INPUT) begin
                    if (cls_hit) begin
                        rcnt_next[cls]   = count_reg;
                        rsize_next[cls]  = size_reg;
                        rstart_next[cls] = pos_reg;
                    end
                    if (pos_sat) begin
                        pos_next = '1;
                        ovf_next = 1'b1;
                    end else begin
                        pos_next = pos_sum[POS_WIDTH-1:0];
                    end
                    usage_next = 32'd0;
                end
            end
        end

        // Summary of the descriptor as it stands after this byte
        result.button_count  = rcnt_next[hidrp_pkg::CLS_BUTTON];
        result.button_bits   = rsize_next[hidrp_pkg::CLS_BUTTON];
        result.axis_count    = rcnt_next[hidrp_pkg::CLS_AXIS];
        result.axis_bits     = rsize_next[hidrp_pkg::CLS_AXIS];
        result.axis_start    = 24'(32'(rstart_next[hidrp_pkg::CLS_AXIS]));
        result.hat_count     = rcnt_next[hidrp_pkg::CLS_HAT];
        result.hat_bits      = rsize_next[hidrp_pkg::CLS_HAT];
        result.hat_start     = 24'(32'(rstart_next[hidrp_pkg::CLS_HAT]));
        result.total_bits    = 24'(32'(pos_next));
        result.stopped_early = stop_next;
        result.pos_overflow  = ovf_next;
        result.button_start  = 24'(32'(rstart_next[hidrp_pkg::CLS_BUTTON]));

        // Last byte: everything clears for the next descriptor
        if (accept && is_last) begin
            prefix_next = 8'd0;
            left_next   = 9'd0;
            accum_next  = 32'd0;
            idx_next    = 2'd0;
            count_next  = 16'd0;
            size_next   = 16'd0;
            usage_next  = 32'd0;
            pos_next    = '0;
            stop_next   = 1'b0;
            ovf_next    = 1'b0;
            for (int k = 0; k < NC; k++) begin
                rcnt_next[k]   = 16'd0;
                rsize_next[k]  = 16'd0;
                rstart_next[k] = '0;
            end
        end
    end

    assign result_valid = accept && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= hidrp_pkg::PH_PREFIX;
            prefix_reg <= 8'd0;
            left_reg   <= 9'd0;
            accum_reg  <= 32'd0;
            idx_reg    <= 2'd0;
            count_reg  <= 16'd0;
            size_reg   <= 16'd0;
            usage_reg  <= 32'd0;
            pos_reg    <= '0;
            stop_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            prod_reg   <= 32'd0;
            for (int k = 0; k < NC; k++) begin
                rcnt_reg[k]   <= 16'd0;
                rsize_reg[k]  <= 16'd0;
                rstart_reg[k] <= '0;
            end
        end else begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            left_reg   <= left_next;
            accum_reg  <= accum_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            size_reg   <= size_next;
            usage_reg  <= usage_next;
            pos_reg    <= pos_next;
            stop_reg   <= stop_next;
            ovf_reg    <= ovf_next;
            // prod_reg lags the globals; the user, not the core, must keep
            // an Input from closing before the last global update reaches it.
            prod_reg   <= 32'(count_reg) * 32'(size_reg);
            rcnt_reg   <= rcnt_next;
            rsize_reg  <= rsize_next;
            rstart_reg <= rstart_next;
        end
    end

endmodule

/* sv/hidrp_out.sv */
// ----------------------------------------------------------------------------
// hidrp_out
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module hidrp_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  hidrp_pkg::result_t  in_data,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output hidrp_pkg::result_t  out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    hidrp_pkg::result_t out_data_reg, out_data_next;
    hidrp_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                if (in_valid) begin
                    out_data_next = in_data;
                end
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/hid_report_descriptor_parser.sv */
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser
// Streaming HID report descriptor walker giving one summary per descriptor.
// ----------------------------------------------------------------------------
// Feed the descriptor one byte per beat on s_*, marking its final byte with
// s_is_last. A byte is accepted every cycle unless a finished summary sits
// in the skid register, which happens only when two summaries wait on a
// stalled m_* side. A descriptor's summary is registered once its last byte
// is accepted, in the skid register if m_* stalls. Short items carry
// 0/1/2/4 value bytes, long items are skipped, Report Count/Size saturate at
// 16 bits, and an Input item records count, size and bit start for buttons,
// axes (usages 0x30..0x35) or hat, then advances the bit position by
// size * count (saturating at 2^POS_WIDTH-1 and flagging pos_overflow). The
// size * count product is registered ahead of use, so the critical path is
// one add and compare on the bit position. A Report ID item matching the
// stop_report_id register (APB offset 0x0, reset 2) freezes parsing until the
// last byte. Write the register only while the block is idle.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser #(
    parameter int POS_WIDTH = hidrp_pkg::POS_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Descriptor byte stream
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_desc_byte,
    input  logic                              s_is_last,

    // Summary results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [15:0]                       m_button_count,
    output logic [15:0]                       m_button_bits,
    output logic [23:0]                       m_button_start,
    output logic [15:0]                       m_axis_count,
    output logic [15:0]                       m_axis_bits,
    output logic [23:0]                       m_axis_start,
    output logic [15:0]                       m_hat_count,
    output logic [15:0]                       m_hat_bits,
    output logic [23:0]                       m_hat_start,
    output logic [23:0]                       m_total_bits,
    output logic                              m_stopped_early,
    output logic                              m_pos_overflow,

    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hidrp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [hidrp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [hidrp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    logic               s_beat;       // byte accepted this cycle
    logic [7:0]         stop_report_id;
    logic               res_valid;
    hidrp_pkg::result_t res_data;
    hidrp_pkg::result_t m_data;

    assign s_beat = s_valid && s_ready;

    hidrp_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .stop_report_id (stop_report_id)
    );

    // Parse state and summary formation
    hidrp_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_beat),
        .desc_byte      (s_desc_byte),
        .is_last        (s_is_last),
        .stop_report_id (stop_report_id),
        .result_valid   (res_valid),
        .result         (res_data)
    );

    // Result register with skid so the byte stream keeps flowing
    hidrp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign m_button_count  = m_data.button_count;
    assign m_button_bits   = m_data.button_bits;
    assign m_button_start  = m_data.button_start;
    assign m_axis_count    = m_data.axis_count;
    assign m_axis_bits     = m_data.axis_bits;
    assign m_axis_start    = m_data.axis_start;
    assign m_hat_count     = m_data.hat_count;
    assign m_hat_bits      = m_data.hat_bits;
    assign m_hat_start     = m_data.hat_start;
    assign m_total_bits    = m_data.total_bits;
    assign m_stopped_early = m_data.stopped_early;
    assign m_pos_overflow  = m_data.pos_overflow;

endmodule
